### design/ipmd_pkg.sv
// ----------------------------------------------------------------------------
// ipmd_pkg: shared types and constants of the PID motor duty block
// Register indexes, fixed field widths, reset values of the control
// registers and the status bundle of the word queue.
// ----------------------------------------------------------------------------
package ipmd_pkg;

	// Fixed widths of the register and result fields.
	localparam int SETPOINT_W = 10;
	localparam int GAIN_W     = 16;
	localparam int GAIN_FRAC  = 8;
	localparam int LIMIT_W    = 8;
	localparam int DUTY_W     = 8;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	// Queue between the front and the back part.
	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETPOINT    = 3'd0,
		REG_GAIN_PROP   = 3'd1,
		REG_GAIN_INT    = 3'd2,
		REG_GAIN_DERIV  = 3'd3,
		REG_DRIVE_LIMIT = 3'd4
	} reg_idx_t;

	// Control register set.
	typedef struct packed {
		logic [SETPOINT_W-1:0] setpoint;
		logic [GAIN_W-1:0]     gain_proportional;
		logic [GAIN_W-1:0]     gain_integral;
		logic [GAIN_W-1:0]     gain_derivative;
		logic [LIMIT_W-1:0]    drive_limit;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		setpoint:          10'd5,
		gain_proportional: 16'd512,
		gain_integral:     16'd205,
		gain_derivative:   16'd154,
		drive_limit:       8'd200
	};

	// Status of the word queue as seen by the front and the back part.
	typedef struct packed {
		logic               not_empty;
		logic [LEVEL_W-1:0] level;
	} queue_stat_t;

endpackage

### design/ipmd_if.sv
// ----------------------------------------------------------------------------
// ipmd_if: handshake channels of the PID motor duty block
// Sample channel into the block and duty channel out of it, each with
// valid, ready and the payload of one word.
// ----------------------------------------------------------------------------
interface ipmd_in_if #(
	parameter int SAMPLE_BITS = 10
) ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] feedback_sample;

	modport source (output valid, output feedback_sample, input ready);
	modport sink (input valid, input feedback_sample, output ready);
endinterface

interface ipmd_out_if ();
	logic       valid;
	logic       ready;
	logic [7:0] pwm_duty;
	logic       saturated;

	modport source (output valid, output pwm_duty, output saturated, input ready);
	modport sink (input valid, input pwm_duty, input saturated, output ready);
endinterface

### design/ipmd_front.sv
// ----------------------------------------------------------------------------
// ipmd_front: sample intake and error terms
// Accepts samples, keeps the error history, forms the two differences and
// the three scaled gain products, and pushes their sum into the queue.
// ----------------------------------------------------------------------------
module ipmd_front #(
	parameter int SAMPLE_BITS = 10,
	parameter int FRAC_BITS   = 8,
	parameter int DATA_W      = 38
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ipmd_pkg::cfg_t        cfg,
	input  ipmd_pkg::queue_stat_t qstat,
	ipmd_in_if.sink               sample_ch,
	output logic                  push,
	output logic [DATA_W-1:0]     push_data
);
	import ipmd_pkg::*;

	localparam int EW    = ((SAMPLE_BITS > SETPOINT_W) ? SAMPLE_BITS : SETPOINT_W) + 1;
	localparam int D1W   = EW + 1;
	localparam int D2W   = EW + 2;
	localparam int PW    = GAIN_W + 1 + D2W;
	localparam int RSH_L = (FRAC_BITS > GAIN_FRAC) ? FRAC_BITS - GAIN_FRAC : 0;
	localparam int RSH_R = (FRAC_BITS < GAIN_FRAC) ? GAIN_FRAC - FRAC_BITS : 0;
	localparam int RW    = PW + RSH_L;
	localparam int BIAS  = (1 << RSH_R) - 1;

	// Rescale a product with GAIN_FRAC fraction bits, truncating toward zero.
	function automatic logic signed [RW-1:0] rescale(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] biased;
		biased = p[PW-1] ? p + PW'(BIAS) : p;
		if (RSH_R == 0) begin
			rescale = RW'(p) <<< RSH_L;
		end else begin
			rescale = RW'(biased >>> RSH_R);
		end
	endfunction

	logic                  accept;
	logic [LEVEL_W:0]      occupancy;
	logic signed [EW-1:0]  err_c;
	logic signed [D1W-1:0] d1_c;
	logic signed [D2W-1:0] d2_c;
	logic signed [EW-1:0]  err1_q;
	logic signed [EW-1:0]  err2_q;

	logic                  v_s1;
	logic signed [EW-1:0]  err_s1;
	logic signed [D1W-1:0] d1_s1;
	logic signed [D2W-1:0] d2_s1;

	logic signed [PW-1:0]  prod_p_c;
	logic signed [PW-1:0]  prod_i_c;
	logic signed [PW-1:0]  prod_d_c;

	logic                  v_s2;
	logic signed [RW-1:0]  term_p_s2;
	logic signed [RW-1:0]  term_i_s2;
	logic signed [RW-1:0]  term_d_s2;

	// Every word in flight already owns a queue slot, so the stages never stall.
	assign occupancy = (LEVEL_W+1)'(qstat.level) + (LEVEL_W+1)'(v_s1) + (LEVEL_W+1)'(v_s2);
	assign sample_ch.ready = occupancy < (LEVEL_W+1)'(QUEUE_DEPTH);
	assign accept = sample_ch.valid && sample_ch.ready;

	// Error and its first and second differences.
	assign err_c = $signed(EW'(cfg.setpoint)) - $signed(EW'(sample_ch.feedback_sample));
	assign d1_c  = D1W'(err_c) - D1W'(err1_q);
	assign d2_c  = D2W'(err_c) - (D2W'(err1_q) <<< 1) + D2W'(err2_q);

	// Error history and stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err1_q <= '0;
			err2_q <= '0;
			v_s1   <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (accept) begin
				err1_q <= err_c;
				err2_q <= err1_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_s1 <= err_c;
			d1_s1  <= d1_c;
			d2_s1  <= d2_c;
		end
	end

	// Gain products, one multiplier per term.
	assign prod_p_c = PW'($signed({1'b0, cfg.gain_proportional})) * PW'(d1_s1);
	assign prod_i_c = PW'($signed({1'b0, cfg.gain_integral})) * PW'(err_s1);
	assign prod_d_c = PW'($signed({1'b0, cfg.gain_derivative})) * PW'(d2_s1);

	// Stage two holds the rescaled terms.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			term_p_s2 <= rescale(prod_p_c);
			term_i_s2 <= rescale(prod_i_c);
			term_d_s2 <= rescale(prod_d_c);
		end
	end

	// Sum of the three terms is the accumulator increment.
	assign push      = v_s2;
	assign push_data = DATA_W'(term_p_s2) + DATA_W'(term_i_s2) + DATA_W'(term_d_s2);

	// The credit check keeps words in flight within the queue depth.
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= (LEVEL_W+1)'(QUEUE_DEPTH))
		else $error("front: words in flight exceed queue depth");

endmodule

### design/ipmd_queue.sv
// ----------------------------------------------------------------------------
// ipmd_queue: word queue between front and back
// A short first-in first-out store of accumulator increments.
// ----------------------------------------------------------------------------
module ipmd_queue #(
	parameter int DATA_W = 38
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [DATA_W-1:0]     push_data,
	input  logic                  pop,
	output logic [DATA_W-1:0]     head_data,
	output ipmd_pkg::queue_stat_t qstat
);
	import ipmd_pkg::*;

	logic [DATA_W-1:0]  mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wptr_q;
	logic [PTR_W-1:0]   rptr_q;
	logic [LEVEL_W-1:0] cnt_q;
	logic               do_pop;

	assign do_pop          = pop && (cnt_q != '0);
	assign head_data       = mem_q[rptr_q];
	assign qstat.not_empty = cnt_q != '0;
	assign qstat.level     = cnt_q;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + LEVEL_W'(push) - LEVEL_W'(do_pop);
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !do_pop && cnt_q == LEVEL_W'(QUEUE_DEPTH)))
		else $error("queue: word pushed while full");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> wptr_q == rptr_q)
		else $error("queue: pointers differ while empty");

endmodule

### design/ipmd_back.sv
// ----------------------------------------------------------------------------
// ipmd_back: drive accumulator and duty output
// Adds each increment to the accumulator, clamps it to the drive limit and
// holds the duty word in an output register.
// ----------------------------------------------------------------------------
module ipmd_back #(
	parameter int FRAC_BITS = 8,
	parameter int DATA_W    = 38
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ipmd_pkg::cfg_t        cfg,
	input  ipmd_pkg::queue_stat_t qstat,
	input  logic [DATA_W-1:0]     head_data,
	output logic                  pop,
	ipmd_out_if.source            duty_ch
);
	import ipmd_pkg::*;

	localparam int AW = FRAC_BITS + LIMIT_W + 1;
	localparam int SW = DATA_W + 1;

	logic signed [AW-1:0] acc_q;
	logic signed [SW-1:0] sum_c;
	logic signed [SW-1:0] bound_c;
	logic signed [AW-1:0] acc_next;
	logic                 sat_c;
	logic                 out_valid_q;
	logic [DUTY_W-1:0]    duty_q;
	logic                 sat_q;

	// Take the next word when the output register is free or being emptied.
	assign pop = qstat.not_empty && (!out_valid_q || duty_ch.ready);

	// Accumulate and clamp to plus or minus the limit.
	assign sum_c   = SW'(acc_q) + SW'($signed(head_data));
	assign bound_c = $signed(SW'({cfg.drive_limit, FRAC_BITS'(0)}));

	always_comb begin
		sat_c    = 1'b0;
		acc_next = AW'(sum_c);
		if (sum_c > bound_c) begin
			sat_c    = 1'b1;
			acc_next = AW'(bound_c);
		end else if (sum_c < -bound_c) begin
			sat_c    = 1'b1;
			acc_next = AW'(-bound_c);
		end
	end

	// Accumulator and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				acc_q       <= acc_next;
				out_valid_q <= 1'b1;
			end else if (duty_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			duty_q <= acc_next[AW-1] ? '0 : acc_next[FRAC_BITS +: DUTY_W];
			sat_q  <= sat_c;
		end
	end

	assign duty_ch.valid     = out_valid_q;
	assign duty_ch.pwm_duty  = duty_q;
	assign duty_ch.saturated = sat_q;

	a_pop_shows: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("back: popped word not presented");

endmodule

### design/incremental_pid_motor_duty.sv
// ----------------------------------------------------------------------------
// incremental_pid_motor_duty: velocity form PID controller for a PWM duty
// Control registers, front part (errors and gain products), word queue and
// back part (accumulator, clamp and duty output).
// ----------------------------------------------------------------------------
//
//   channel     dir  handshake      word
//   sample_ch   in   valid/ready    feedback_sample
//   duty_ch     out  valid/ready    pwm_duty, saturated
//   cfg port    in   cfg_we         cfg_index, cfg_data
//
// One sample per cycle sustained while the output does not stall; the
// accumulator add and clamp loop in the back part sets that rate.
// A result passes stage one, stage two, the queue and the output register.
// Reset loads the register defaults and clears error history and accumulator.
// A four-word queue with credit on the input lets the output stall freely;
// samples are refused once the two front stages and the queue hold four words.
//
module incremental_pid_motor_duty #(
	parameter int SAMPLE_BITS = 10,
	parameter int FRAC_BITS   = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ipmd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ipmd_pkg::CFG_DATA_W-1:0]     cfg_data,
	ipmd_in_if.sink                             sample_ch,
	ipmd_out_if.source                          duty_ch
);
	import ipmd_pkg::*;

	localparam int EW     = ((SAMPLE_BITS > SETPOINT_W) ? SAMPLE_BITS : SETPOINT_W) + 1;
	localparam int PW     = GAIN_W + 1 + EW + 2;
	localparam int RSH_L  = (FRAC_BITS > GAIN_FRAC) ? FRAC_BITS - GAIN_FRAC : 0;
	localparam int DATA_W = PW + RSH_L + 2;

	cfg_t              cfg_q;
	queue_stat_t       qstat;
	logic              push;
	logic [DATA_W-1:0] push_data;
	logic              pop;
	logic [DATA_W-1:0] head_data;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SETPOINT:    cfg_q.setpoint          <= cfg_data[SETPOINT_W-1:0];
				REG_GAIN_PROP:   cfg_q.gain_proportional <= cfg_data[GAIN_W-1:0];
				REG_GAIN_INT:    cfg_q.gain_integral     <= cfg_data[GAIN_W-1:0];
				REG_GAIN_DERIV:  cfg_q.gain_derivative   <= cfg_data[GAIN_W-1:0];
				REG_DRIVE_LIMIT: cfg_q.drive_limit       <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	ipmd_front #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRAC_BITS  (FRAC_BITS),
		.DATA_W     (DATA_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.qstat    (qstat),
		.sample_ch(sample_ch),
		.push     (push),
		.push_data(push_data)
	);

	ipmd_queue #(
		.DATA_W(DATA_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head_data(head_data),
		.qstat    (qstat)
	);

	ipmd_back #(
		.FRAC_BITS(FRAC_BITS),
		.DATA_W   (DATA_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.qstat    (qstat),
		.head_data(head_data),
		.pop      (pop),
		.duty_ch  (duty_ch)
	);

endmodule
